// ===== design/art_pkg.sv =====
// Shared types, constants and codes for the ACK retry tracker.
package art_pkg;

    localparam int SLOTS_DEF = 8;

    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int MID_W    = 16;
    localparam int FRAG_W   = 8;
    localparam int CALL_W   = 56;
    localparam int HANDLE_W = 8;
    localparam int RETRY_W  = 8;
    localparam int TIME_W   = 32;
    localparam int CNT_W    = 32;
    localparam int PLEN_W   = 8;

    localparam logic [TIME_W-1:0]  TIMEOUT_RESET     = 32'd5000;
    localparam logic [RETRY_W-1:0] MAX_RETRIES_RESET = 8'd3;
    localparam logic [PLEN_W-1:0]  MIN_ACK_PAYLOAD   = 8'd3;

    typedef enum logic [1:0] {
        ACT_TRACK = 2'd0,
        ACT_ACK   = 2'd1,
        ACT_POLL  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic {
        REG_TIMEOUT     = 1'b0,
        REG_MAX_RETRIES = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
    } t_dp_status;

    typedef struct packed {
        logic [MID_W-1:0]    message_id;
        logic [FRAG_W-1:0]   fragment;
        logic [CALL_W-1:0]   destination;
        logic [HANDLE_W-1:0] handle;
        logic [RETRY_W-1:0]  retries;
        logic [TIME_W-1:0]   last_send;
    } t_entry;

endpackage

// ===== design/art_ctrl.sv =====
// Controller state machine that sequences load, slot scan and result delivery.
module art_ctrl import art_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_stall,
    output logic       o_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_stall  = 1'b1;
        o_valid  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/art_dp.sv =====
// Datapath with the slot table, the one-slot-per-cycle scan and the result registers.
module art_dp import art_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  logic [1:0]          i_action,
    input  logic [TIME_W-1:0]   i_now_ms,
    input  logic [MID_W-1:0]    i_message_id,
    input  logic [FRAG_W-1:0]   i_fragment_index,
    input  logic [CALL_W-1:0]   i_callsign,
    input  logic [HANDLE_W-1:0] i_packet_handle,
    input  logic                i_is_ack_type,
    input  logic [PLEN_W-1:0]   i_payload_length,
    input  logic [MID_W-1:0]    i_acked_id,
    input  logic [FRAG_W-1:0]   i_acked_fragment,
    input  logic [TIME_W-1:0]   i_timeout,
    input  logic [RETRY_W-1:0]  i_max_retries,
    output logic                o_ok,
    output logic                o_gave_up,
    output logic [HANDLE_W-1:0] o_retry_handle,
    output logic [MID_W-1:0]    o_retry_message_id,
    output logic [FRAG_W-1:0]   o_retry_fragment,
    output logic [CALL_W-1:0]   o_retry_destination,
    output logic [CNT_W-1:0]    o_total_retries,
    output logic [CNT_W-1:0]    o_total_failures
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] SLOT_CNT = CW'(SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    t_entry r_mem [SLOTS];
    t_entry r_rd;
    t_entry wr_entry;

    logic [SLOTS-1:0]    r_active;
    logic [CW-1:0]       r_idx;
    logic [IW-1:0]       r_ev_idx;
    logic                r_ev_vld;

    t_action             r_action;
    logic [TIME_W-1:0]   r_now;
    logic [MID_W-1:0]    r_mid;
    logic [FRAG_W-1:0]   r_frag;
    logic [CALL_W-1:0]   r_call;
    logic [HANDLE_W-1:0] r_handle;
    logic                r_ack_ok;
    logic [MID_W-1:0]    r_aid;
    logic [FRAG_W-1:0]   r_afrag;

    logic                r_ok;
    logic                r_gave;
    logic [HANDLE_W-1:0] r_rh;
    logic [MID_W-1:0]    r_rid;
    logic [FRAG_W-1:0]   r_rfr;
    logic [CALL_W-1:0]   r_rdst;
    logic [CNT_W-1:0]    r_retry_cnt;
    logic [CNT_W-1:0]    r_fail_cnt;

    logic                ev_act;
    logic [TIME_W-1:0]   elapsed;
    logic                due;
    logic                give;
    logic                hit;
    logic                stop;
    logic                ev_hit;
    logic                done;
    logic                issue;
    logic                mem_we;

    always_comb begin
        ev_act  = r_active[r_ev_idx];
        elapsed = r_now - r_rd.last_send;
        due     = (elapsed >= i_timeout);
        give    = (r_rd.retries >= i_max_retries);
        hit     = 1'b0;
        stop    = 1'b0;
        case (r_action)
            ACT_TRACK: begin
                hit  = !ev_act;
                stop = hit;
            end
            ACT_ACK: begin
                hit = ev_act && r_ack_ok && (r_rd.message_id == r_aid) &&
                      (r_rd.fragment == r_afrag) && (r_rd.destination == r_call);
            end
            ACT_POLL: begin
                hit  = ev_act && due;
                stop = hit;
            end
            ACT_CLEAR: begin
                hit = ev_act && (r_rd.message_id == r_mid) &&
                      (r_rd.destination == r_call);
            end
            default: begin
                hit = 1'b0;
            end
        endcase
        ev_hit = r_ev_vld && hit;
        done   = r_ev_vld && (stop || (r_ev_idx == LAST_IDX));
        issue  = i_cmd.scan && !done && (r_idx < SLOT_CNT);
        mem_we = ev_hit && ((r_action == ACT_TRACK) || ((r_action == ACT_POLL) && !give));

        wr_entry = r_rd;
        if (r_action == ACT_TRACK) begin
            wr_entry.message_id  = r_mid;
            wr_entry.fragment    = r_frag;
            wr_entry.destination = r_call;
            wr_entry.handle      = r_handle;
            wr_entry.retries     = '0;
            wr_entry.last_send   = r_now;
        end else begin
            wr_entry.retries   = r_rd.retries + RETRY_W'(1);
            wr_entry.last_send = r_now;
        end
    end

    assign o_status.done = done;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_ev_idx] <= wr_entry;
        end
        if (issue) begin
            r_rd <= r_mem[r_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_now    <= i_now_ms;
            r_mid    <= i_message_id;
            r_frag   <= i_fragment_index;
            r_call   <= i_callsign;
            r_handle <= i_packet_handle;
            r_ack_ok <= i_is_ack_type && (i_payload_length >= MIN_ACK_PAYLOAD);
            r_aid    <= i_acked_id;
            r_afrag  <= i_acked_fragment;
        end
        if (issue) begin
            r_ev_idx <= r_idx[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_idx       <= '0;
            r_ev_vld    <= 1'b0;
            r_ok        <= 1'b0;
            r_gave      <= 1'b0;
            r_rh        <= '0;
            r_rid       <= '0;
            r_rfr       <= '0;
            r_rdst      <= '0;
            r_retry_cnt <= '0;
            r_fail_cnt  <= '0;
        end else begin
            r_ev_vld <= issue;
            if (i_cmd.load) begin
                r_idx  <= '0;
                r_ok   <= 1'b0;
                r_gave <= 1'b0;
                r_rh   <= '0;
                r_rid  <= '0;
                r_rfr  <= '0;
                r_rdst <= '0;
            end else if (issue) begin
                r_idx <= r_idx + CW'(1);
            end
            if (ev_hit) begin
                case (r_action)
                    ACT_TRACK: begin
                        r_active[r_ev_idx] <= 1'b1;
                        r_ok               <= 1'b1;
                    end
                    ACT_POLL: begin
                        if (give) begin
                            r_active[r_ev_idx] <= 1'b0;
                            r_gave             <= 1'b1;
                            r_fail_cnt         <= r_fail_cnt + CNT_W'(1);
                        end else begin
                            r_ok        <= 1'b1;
                            r_rh        <= r_rd.handle;
                            r_rid       <= r_rd.message_id;
                            r_rfr       <= r_rd.fragment;
                            r_rdst      <= r_rd.destination;
                            r_retry_cnt <= r_retry_cnt + CNT_W'(1);
                        end
                    end
                    ACT_ACK: begin
                        r_active[r_ev_idx] <= 1'b0;
                        r_ok               <= 1'b1;
                    end
                    ACT_CLEAR: begin
                        r_active[r_ev_idx] <= 1'b0;
                    end
                    default: begin
                        r_ok <= r_ok;
                    end
                endcase
            end
        end
    end

    assign o_ok                = r_ok;
    assign o_gave_up           = r_gave;
    assign o_retry_handle      = r_rh;
    assign o_retry_message_id  = r_rid;
    assign o_retry_fragment    = r_rfr;
    assign o_retry_destination = r_rdst;
    assign o_total_retries     = r_retry_cnt;
    assign o_total_failures    = r_fail_cnt;

endmodule

// ===== design/ack_retry_tracker_core.sv =====
// Top level of the ACK retry tracker: configuration registers, controller and datapath.
// Track and poll end early at the first free or due slot; acknowledge and clear visit all slots.
// The slot table is read one entry per cycle through a single registered read port.
// Only one beat is in flight: a new beat is taken only after the result of the last one is accepted.
// Synchronous reset clears all slots, both counters and loads the register defaults.
module ack_retry_tracker_core import art_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_action,
    input  logic [TIME_W-1:0]   i_now_ms,
    input  logic [MID_W-1:0]    i_message_id,
    input  logic [FRAG_W-1:0]   i_fragment_index,
    input  logic [CALL_W-1:0]   i_callsign,
    input  logic [HANDLE_W-1:0] i_packet_handle,
    input  logic                i_is_ack_type,
    input  logic [PLEN_W-1:0]   i_payload_length,
    input  logic [MID_W-1:0]    i_acked_id,
    input  logic [FRAG_W-1:0]   i_acked_fragment,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_ok,
    output logic                o_gave_up,
    output logic [HANDLE_W-1:0] o_retry_handle,
    output logic [MID_W-1:0]    o_retry_message_id,
    output logic [FRAG_W-1:0]   o_retry_fragment,
    output logic [CALL_W-1:0]   o_retry_destination,
    output logic [CNT_W-1:0]    o_total_retries,
    output logic [CNT_W-1:0]    o_total_failures,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    logic [TIME_W-1:0]  r_timeout;
    logic [RETRY_W-1:0] r_max_retries;
    t_reg_idx           reg_idx;
    logic               cfg_wr;
    t_dp_cmd            dp_cmd;
    t_dp_status         dp_status;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout     <= TIMEOUT_RESET;
            r_max_retries <= MAX_RETRIES_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_TIMEOUT:     r_timeout     <= pwdata;
                REG_MAX_RETRIES: r_max_retries <= pwdata[RETRY_W-1:0];
                default:         r_timeout     <= r_timeout;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TIMEOUT:     prdata = r_timeout;
            REG_MAX_RETRIES: prdata = {{(DATA_W-RETRY_W){1'b0}}, r_max_retries};
            default:         prdata = '0;
        endcase
    end

    art_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_stall  (i_stall),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_stall  (o_stall),
        .o_valid  (o_valid)
    );

    art_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (dp_cmd),
        .o_status            (dp_status),
        .i_action            (i_action),
        .i_now_ms            (i_now_ms),
        .i_message_id        (i_message_id),
        .i_fragment_index    (i_fragment_index),
        .i_callsign          (i_callsign),
        .i_packet_handle     (i_packet_handle),
        .i_is_ack_type       (i_is_ack_type),
        .i_payload_length    (i_payload_length),
        .i_acked_id          (i_acked_id),
        .i_acked_fragment    (i_acked_fragment),
        .i_timeout           (r_timeout),
        .i_max_retries       (r_max_retries),
        .o_ok                (o_ok),
        .o_gave_up           (o_gave_up),
        .o_retry_handle      (o_retry_handle),
        .o_retry_message_id  (o_retry_message_id),
        .o_retry_fragment    (o_retry_fragment),
        .o_retry_destination (o_retry_destination),
        .o_total_retries     (o_total_retries),
        .o_total_failures    (o_total_failures)
    );

    a_no_accept_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input beat could be accepted while a result is pending");

    a_ok_excludes_gave_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_ok && o_gave_up))
        else $error("result reports both a retry and an abandoned frame");

    a_retry_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_retry_handle == '0 && o_retry_message_id == '0 &&
                                o_retry_fragment == '0 && o_retry_destination == '0))
        else $error("retry fields are nonzero on a result without a retry");

    a_failures_only_on_give_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) && !o_gave_up |-> $stable(o_total_failures))
        else $error("failure count moved without an abandoned frame");

endmodule

// ===== bench/ack_retry_tracker_core_test.sv =====
// Self-checking testbench for ack_retry_tracker_core: a directed table, then randomized traffic.
module ack_retry_tracker_core_test;
    import art_pkg::*;

    localparam int NSLOT           = SLOTS_DEF;
    localparam int SETTLE          = NSLOT + 8;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 5;
    localparam int BEATS_PER_PHASE = 106;
    localparam int PRINT_CAP       = 100;

    localparam logic [CALL_W-1:0] ONES_DEST = {CALL_W{1'b1}};
    localparam logic [CALL_W-1:0] DUP_DEST  = 56'h5A3C960FE1772B;
    localparam logic [CALL_W-1:0] ALT_DEST  = 56'hAAAAAAAAAAAAAA;
    localparam logic [CALL_W-1:0] WRAP_DEST = 56'h123456789ABCDE;

    typedef struct {
        t_action             action;
        logic [TIME_W-1:0]   now_ms;
        logic [MID_W-1:0]    message_id;
        logic [FRAG_W-1:0]   fragment_index;
        logic [CALL_W-1:0]   callsign;
        logic [HANDLE_W-1:0] packet_handle;
        logic                is_ack;
        logic [PLEN_W-1:0]   payload_length;
        logic [MID_W-1:0]    acked_id;
        logic [FRAG_W-1:0]   acked_fragment;
    } t_beat;

    typedef struct {
        logic                ok;
        logic                gave_up;
        logic [HANDLE_W-1:0] handle;
        logic [MID_W-1:0]    message_id;
        logic [FRAG_W-1:0]   fragment;
        logic [CALL_W-1:0]   destination;
        logic [CNT_W-1:0]    retries;
        logic [CNT_W-1:0]    failures;
    } t_reply;

    typedef struct {
        t_beat  b;
        int     phase;
        bit     typed;
        t_reply want;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [1:0]          i_action;
    logic [TIME_W-1:0]   i_now_ms;
    logic [MID_W-1:0]    i_message_id;
    logic [FRAG_W-1:0]   i_fragment_index;
    logic [CALL_W-1:0]   i_callsign;
    logic [HANDLE_W-1:0] i_packet_handle;
    logic                i_is_ack_type;
    logic [PLEN_W-1:0]   i_payload_length;
    logic [MID_W-1:0]    i_acked_id;
    logic [FRAG_W-1:0]   i_acked_fragment;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic                o_ok;
    logic                o_gave_up;
    logic [HANDLE_W-1:0] o_retry_handle;
    logic [MID_W-1:0]    o_retry_message_id;
    logic [FRAG_W-1:0]   o_retry_fragment;
    logic [CALL_W-1:0]   o_retry_destination;
    logic [CNT_W-1:0]    o_total_retries;
    logic [CNT_W-1:0]    o_total_failures;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Shadow copy of the slot table, counters and registers.
    logic              slot_busy [NSLOT];
    t_entry            shadow [NSLOT];
    logic [CNT_W-1:0]  retry_total;
    logic [CNT_W-1:0]  failure_total;
    logic [TIME_W-1:0] cfg_timeout;
    logic [RETRY_W-1:0] cfg_max_retries;

    t_reply reply_q [$];

    logic [TIME_W-1:0] clock_ms;
    logic [MID_W-1:0]  id_pool [4];
    logic [CALL_W-1:0] dest_pool [4];

    int  mismatches  = 0;
    int  beats_sent  = 0;
    int  cycle_count = 0;
    int  burst_left  = 0;
    bit  no_gaps     = 1'b0;
    int  stall_span  = 0;
    int  stall_mode  = 0;
    int  n_gave      = 0;
    int  n_full      = 0;
    int  n_multi     = 0;
    int  n_phases    = 0;

    ack_retry_tracker_core uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_action            (i_action),
        .i_now_ms            (i_now_ms),
        .i_message_id        (i_message_id),
        .i_fragment_index    (i_fragment_index),
        .i_callsign          (i_callsign),
        .i_packet_handle     (i_packet_handle),
        .i_is_ack_type       (i_is_ack_type),
        .i_payload_length    (i_payload_length),
        .i_acked_id          (i_acked_id),
        .i_acked_fragment    (i_acked_fragment),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_ok                (o_ok),
        .o_gave_up           (o_gave_up),
        .o_retry_handle      (o_retry_handle),
        .o_retry_message_id  (o_retry_message_id),
        .o_retry_fragment    (o_retry_fragment),
        .o_retry_destination (o_retry_destination),
        .o_total_retries     (o_total_retries),
        .o_total_failures    (o_total_failures),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_beat beat_of(input t_action act, input logic [TIME_W-1:0] now,
                                      input logic [MID_W-1:0] mid, input logic [FRAG_W-1:0] frag,
                                      input logic [CALL_W-1:0] call,
                                      input logic [HANDLE_W-1:0] handle, input logic is_ack,
                                      input logic [PLEN_W-1:0] plen, input logic [MID_W-1:0] aid,
                                      input logic [FRAG_W-1:0] afrag);
        t_beat b;
        b.action         = act;
        b.now_ms         = now;
        b.message_id     = mid;
        b.fragment_index = frag;
        b.callsign       = call;
        b.packet_handle  = handle;
        b.is_ack         = is_ack;
        b.payload_length = plen;
        b.acked_id       = aid;
        b.acked_fragment = afrag;
        return b;
    endfunction

    function automatic t_reply typed_reply(input logic ok, input logic gave,
                                           input logic [CNT_W-1:0] ret,
                                           input logic [CNT_W-1:0] fail);
        t_reply r;
        r = '{default: '0};
        r.ok       = ok;
        r.gave_up  = gave;
        r.retries  = ret;
        r.failures = fail;
        return r;
    endfunction

    // Applies one beat to the shadow table and returns the answer the block must give.
    function automatic t_reply tracker_reply(input t_beat b);
        t_reply            r;
        bit                found;
        int                hits;
        logic [TIME_W-1:0] elapsed;
        r = '{default: '0};
        found = 1'b0;
        hits = 0;
        case (b.action)
            ACT_TRACK: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (!found && !slot_busy[i]) begin
                        found = 1'b1;
                        slot_busy[i]             = 1'b1;
                        shadow[i].message_id     = b.message_id;
                        shadow[i].fragment       = b.fragment_index;
                        shadow[i].destination    = b.callsign;
                        shadow[i].handle         = b.packet_handle;
                        shadow[i].retries        = '0;
                        shadow[i].last_send      = b.now_ms;
                    end
                end
                r.ok = found;
                if (!found) n_full++;
            end
            ACT_ACK: begin
                if (b.is_ack && b.payload_length >= MIN_ACK_PAYLOAD) begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (slot_busy[i] && shadow[i].message_id == b.acked_id &&
                            shadow[i].fragment == b.acked_fragment &&
                            shadow[i].destination == b.callsign) begin
                            slot_busy[i] = 1'b0;
                            hits++;
                        end
                    end
                end
                r.ok = (hits > 0);
                if (hits > 1) n_multi++;
            end
            ACT_POLL: begin
                for (int i = 0; i < NSLOT; i++) begin
                    elapsed = b.now_ms - shadow[i].last_send;
                    if (!found && slot_busy[i] && elapsed >= cfg_timeout) begin
                        found = 1'b1;
                        if (shadow[i].retries >= cfg_max_retries) begin
                            slot_busy[i] = 1'b0;
                            failure_total = failure_total + 1'b1;
                            r.gave_up = 1'b1;
                            n_gave++;
                        end else begin
                            shadow[i].last_send = b.now_ms;
                            shadow[i].retries   = shadow[i].retries + 1'b1;
                            retry_total = retry_total + 1'b1;
                            r.ok          = 1'b1;
                            r.handle      = shadow[i].handle;
                            r.message_id  = shadow[i].message_id;
                            r.fragment    = shadow[i].fragment;
                            r.destination = shadow[i].destination;
                        end
                    end
                end
            end
            default: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (slot_busy[i] && shadow[i].message_id == b.message_id &&
                        shadow[i].destination == b.callsign)
                        slot_busy[i] = 1'b0;
                end
            end
        endcase
        r.retries  = retry_total;
        r.failures = failure_total;
        return r;
    endfunction

    // Random beat; most acks and clears aim at frames that are really pending.
    function automatic t_beat random_beat();
        t_beat             b;
        int                pick;
        int                k;
        int                live [$];
        logic [TIME_W-1:0] span;
        span = (cfg_timeout == 0) ? 32'd50 :
               ((cfg_timeout > 32'd100000) ? 32'd100000 : cfg_timeout);
        pick = $urandom_range(0, 99);
        if (pick < 8)
            clock_ms = clock_ms + $urandom;
        else if (pick < 55)
            clock_ms = clock_ms + $urandom_range(0, span / 4);
        else
            clock_ms = clock_ms + $urandom_range(0, span + span / 2);
        b = beat_of(t_action'($urandom_range(0, 3)), clock_ms, MID_W'($urandom),
                    FRAG_W'($urandom), CALL_W'({$urandom, $urandom}), HANDLE_W'($urandom),
                    1'($urandom), PLEN_W'($urandom), MID_W'($urandom), FRAG_W'($urandom));
        if ($urandom_range(0, 1) == 1)
            b.payload_length = PLEN_W'($urandom_range(0, 5));
        foreach (slot_busy[i])
            if (slot_busy[i]) live.push_back(i);
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            b.action = ACT_TRACK;
            if ($urandom_range(0, 99) < 40) begin
                k = $urandom_range(0, 3);
                b.message_id     = id_pool[k];
                b.callsign       = dest_pool[k];
                b.fragment_index = FRAG_W'(k);
            end
        end else if (pick < 60) begin
            b.action = ACT_ACK;
            if (live.size() > 0 && $urandom_range(0, 99) < 75) begin
                k = live[$urandom_range(0, live.size() - 1)];
                b.acked_id       = shadow[k].message_id;
                b.acked_fragment = shadow[k].fragment;
                b.callsign       = shadow[k].destination;
                b.is_ack         = 1'b1;
                b.payload_length = PLEN_W'($urandom_range(3, 255));
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    b.is_ack = 1'b0;
                else if (pick < 16)
                    b.payload_length = PLEN_W'($urandom_range(0, 2));
            end
        end else if (pick < 88) begin
            b.action = ACT_POLL;
        end else begin
            b.action = ACT_CLEAR;
            if (live.size() > 0 && $urandom_range(0, 99) < 70) begin
                k = live[$urandom_range(0, live.size() - 1)];
                b.message_id = shadow[k].message_id;
                b.callsign   = shadow[k].destination;
            end
        end
        return b;
    endfunction

    task automatic set_register(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TIMEOUT:     cfg_timeout = value[TIME_W-1:0];
            REG_MAX_RETRIES: cfg_max_retries = value[RETRY_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Offers one beat, with a random gap at the start of each burst unless no_gaps is set, and waits for acceptance.
    task automatic send_beat(input t_beat b, input bit typed, input t_reply want);
        int     gap;
        t_reply answer;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (!no_gaps) gap = $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_action         <= b.action;
        i_now_ms         <= b.now_ms;
        i_message_id     <= b.message_id;
        i_fragment_index <= b.fragment_index;
        i_callsign       <= b.callsign;
        i_packet_handle  <= b.packet_handle;
        i_is_ack_type    <= b.is_ack;
        i_payload_length <= b.payload_length;
        i_acked_id       <= b.acked_id;
        i_acked_fragment <= b.acked_fragment;
        do @(posedge i_clk); while (o_stall);
        answer = tracker_reply(b);
        reply_q.push_back(typed ? want : answer);
        beats_sent++;
    endtask

    task automatic finish_phase();
        i_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        n_phases++;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch %0d at cycle %0d: %s got %0h want %0h",
                     mismatches, cycle_count, what, got, want);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, reply_q.size());
            $display("ack_retry_tracker_core_test: FAIL");
            $finish;
        end
    end

    // Receiver: free-running stretches, random stalls and long stalls.
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_span = (stall_mode == 0) ? $urandom_range(10, 60) : $urandom_range(1, 25);
        end
        stall_span--;
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 1) == 1);
            default: i_stall <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (reply_q.size() == 0) begin
                report_mismatch("result beat with nothing pending", 64'(o_ok), 64'd0);
            end else begin
                want = reply_q.pop_front();
                if (o_ok !== want.ok)
                    report_mismatch("ok", 64'(o_ok), 64'(want.ok));
                if (o_gave_up !== want.gave_up)
                    report_mismatch("gave_up", 64'(o_gave_up), 64'(want.gave_up));
                if (o_retry_handle !== want.handle)
                    report_mismatch("retry_handle", 64'(o_retry_handle), 64'(want.handle));
                if (o_retry_message_id !== want.message_id)
                    report_mismatch("retry_message_id", 64'(o_retry_message_id),
                                    64'(want.message_id));
                if (o_retry_fragment !== want.fragment)
                    report_mismatch("retry_fragment", 64'(o_retry_fragment),
                                    64'(want.fragment));
                if (o_retry_destination !== want.destination)
                    report_mismatch("retry_destination", 64'(o_retry_destination),
                                    64'(want.destination));
                if (o_total_retries !== want.retries)
                    report_mismatch("total_retries", 64'(o_total_retries), 64'(want.retries));
                if (o_total_failures !== want.failures)
                    report_mismatch("total_failures", 64'(o_total_failures),
                                    64'(want.failures));
            end
        end
    end

    initial begin
        t_row   rows [$];
        t_reply blank;
        blank = '{default: '0};

        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_action         <= ACT_TRACK;
        i_now_ms         <= '0;
        i_message_id     <= '0;
        i_fragment_index <= '0;
        i_callsign       <= '0;
        i_packet_handle  <= '0;
        i_is_ack_type    <= 1'b0;
        i_payload_length <= '0;
        i_acked_id       <= '0;
        i_acked_fragment <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;

        foreach (slot_busy[i]) begin
            slot_busy[i] = 1'b0;
            shadow[i]    = '0;
        end
        retry_total     = '0;
        failure_total   = '0;
        cfg_timeout     = TIMEOUT_RESET;
        cfg_max_retries = MAX_RETRIES_RESET;

        // Default registers: track, rejected and accepted acks, retry, full table, clear.
        rows.push_back('{beat_of(ACT_TRACK, 32'd0, 16'hFFFF, 8'hFF, ONES_DEST, 8'hFF,
                                 1'b0, 8'd0, 16'd0, 8'd0), 0, 1'b1, typed_reply(1, 0, 0, 0)});
        rows.push_back('{beat_of(ACT_TRACK, 32'd10, 16'h0000, 8'h00, '0, 8'h00,
                                 1'b1, 8'hFF, 16'hFFFF, 8'hFF), 0, 1'b1,
                         typed_reply(1, 0, 0, 0)});
        rows.push_back('{beat_of(ACT_ACK, 32'hFFFFFFFF, 16'h0, 8'h0, ONES_DEST, 8'h0,
                                 1'b0, 8'hFF, 16'hFFFF, 8'hFF), 0, 1'b1,
                         typed_reply(0, 0, 0, 0)});
        rows.push_back('{beat_of(ACT_ACK, 32'd0, 16'h0, 8'h0, ONES_DEST, 8'h0,
                                 1'b1, 8'd2, 16'hFFFF, 8'hFF), 0, 1'b1,
                         typed_reply(0, 0, 0, 0)});
        rows.push_back('{beat_of(ACT_ACK, 32'd0, 16'h0, 8'h0, ONES_DEST, 8'h0,
                                 1'b1, 8'd3, 16'hFFFF, 8'hFF), 0, 1'b0, blank});
        rows.push_back('{beat_of(ACT_POLL, 32'd4999, 16'h0, 8'h0, '0, 8'h0,
                                 1'b0, 8'd0, 16'd0, 8'd0), 0, 1'b0, blank});
        rows.push_back('{beat_of(ACT_POLL, 32'd5010, 16'h0, 8'h0, '0, 8'h0,
                                 1'b0, 8'd0, 16'd0, 8'd0), 0, 1'b0, blank});
        for (int n = 0; n < NSLOT - 1; n++)
            rows.push_back('{beat_of(ACT_TRACK, 32'd6000, 16'h1234, 8'h07, DUP_DEST,
                                     HANDLE_W'(n), 1'b0, 8'd0, 16'd0, 8'd0), 0, 1'b0, blank});
        rows.push_back('{beat_of(ACT_TRACK, 32'd6001, 16'h4321, 8'h01, ALT_DEST, 8'h11,
                                 1'b0, 8'd0, 16'd0, 8'd0), 0, 1'b1, typed_reply(0, 0, 1, 0)});
        rows.push_back('{beat_of(ACT_ACK, 32'd6002, 16'h0, 8'h0, DUP_DEST, 8'h0,
                                 1'b1, 8'd3, 16'h1234, 8'h07), 0, 1'b0, blank});
        rows.push_back('{beat_of(ACT_CLEAR, 32'd6003, 16'h0000, 8'h0, '0, 8'h0,
                                 1'b0, 8'd0, 16'd0, 8'd0), 0, 1'b1, typed_reply(0, 0, 1, 0)});
        // Zero timeout and zero retries: the first poll abandons the frame.
        rows.push_back('{beat_of(ACT_TRACK, 32'h89ABCDEF, 16'h5555, 8'hAA, ALT_DEST, 8'h55,
                                 1'b0, 8'd0, 16'd0, 8'd0), 1, 1'b1, typed_reply(1, 0, 1, 0)});
        rows.push_back('{beat_of(ACT_POLL, 32'h89ABCDEF, 16'h0, 8'h0, '0, 8'h0,
                                 1'b0, 8'd0, 16'd0, 8'd0), 1, 1'b1, typed_reply(0, 1, 1, 1)});
        // Largest timeout: only a full wrap of the clock makes the frame due.
        rows.push_back('{beat_of(ACT_TRACK, 32'd1, 16'h002A, 8'h03, WRAP_DEST, 8'h09,
                                 1'b0, 8'd0, 16'd0, 8'd0), 2, 1'b1, typed_reply(1, 0, 1, 1)});
        rows.push_back('{beat_of(ACT_POLL, 32'd0, 16'h0, 8'h0, '0, 8'h0,
                                 1'b0, 8'd0, 16'd0, 8'd0), 2, 1'b0, blank});
        rows.push_back('{beat_of(ACT_POLL, 32'd0, 16'h0, 8'h0, '0, 8'h0,
                                 1'b0, 8'd0, 16'd0, 8'd0), 2, 1'b0, blank});
        rows.push_back('{beat_of(ACT_ACK, 32'd5, 16'h0, 8'h0, WRAP_DEST, 8'h0,
                                 1'b1, 8'd200, 16'h002A, 8'h04), 2, 1'b0, blank});
        rows.push_back('{beat_of(ACT_CLEAR, 32'd6, 16'h002A, 8'h0, WRAP_DEST, 8'h0,
                                 1'b0, 8'd0, 16'd0, 8'd0), 2, 1'b1, typed_reply(0, 0, 2, 1)});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < 3; p++) begin
            if (p == 1) begin
                set_register(REG_TIMEOUT, 32'd0);
                set_register(REG_MAX_RETRIES, 32'd0);
            end else if (p == 2) begin
                set_register(REG_TIMEOUT, 32'hFFFFFFFF);
                set_register(REG_MAX_RETRIES, 32'h000000FF);
            end
            foreach (rows[i])
                if (rows[i].phase == p) send_beat(rows[i].b, rows[i].typed, rows[i].want);
            finish_phase();
        end

        clock_ms = $urandom;
        foreach (id_pool[i]) begin
            id_pool[i]   = MID_W'($urandom);
            dest_pool[i] = CALL_W'({$urandom, $urandom});
        end
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    set_register(REG_TIMEOUT, 32'd5000);
                    set_register(REG_MAX_RETRIES, 32'd3);
                end
                1: begin
                    set_register(REG_TIMEOUT, $urandom_range(1, 300));
                    set_register(REG_MAX_RETRIES, {$urandom_range(0, 255) << 8} |
                                 $urandom_range(0, 4));
                end
                2: begin
                    set_register(REG_TIMEOUT, 32'd0);
                    set_register(REG_MAX_RETRIES, 32'd1);
                end
                3: begin
                    set_register(REG_TIMEOUT, $urandom_range(1, 2000));
                    set_register(REG_MAX_RETRIES, 32'd255);
                end
                default: begin
                    set_register(REG_TIMEOUT, 32'hFFFFFFFF);
                    set_register(REG_MAX_RETRIES, 32'd0);
                end
            endcase
            no_gaps = (p == 2);
            for (int n = 0; n < BEATS_PER_PHASE; n++)
                send_beat(random_beat(), 1'b0, blank);
            finish_phase();
        end

        $display("covered %0d beats under %0d register settings in %0d cycles",
                 beats_sent, n_phases, cycle_count);
        $display("retries %0d, give-ups %0d, full-table rejects %0d, multi-slot acks %0d",
                 retry_total, n_gave, n_full, n_multi);
        if (mismatches == 0) begin
            $display("ack_retry_tracker_core_test: PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("ack_retry_tracker_core_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== ack_retry_tracker_core.f =====
design/art_pkg.sv
design/art_ctrl.sv
design/art_dp.sv
design/ack_retry_tracker_core.sv
bench/ack_retry_tracker_core_test.sv
